>>> hdl/tss_pkg.sv
`default_nettype none

package tss_pkg;

  localparam int MAX_TASKS_DEF = 8;
  localparam int COUNT_LIMIT   = 500;

  localparam int TIME_W    = 24;
  localparam int SLEEP_W   = 25;
  localparam int CNT_W     = 16;
  localparam int PRIO_W    = 8;
  localparam int WEIGHT_W  = 8;
  localparam int TCOUNT_W  = 4;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;
  localparam int SLOT_W    = 3;
  localparam int OP_W      = 2;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_DELAY = 2'd1,
    OP_SCHED = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    TS_READY = 2'd0,
    TS_WAIT  = 2'd1,
    TS_RUN   = 2'd2
  } task_st_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TASK_COUNT   = 2'd0,
    CFG_PRIORITIES   = 2'd1,
    CFG_PRIO_WEIGHT  = 2'd2,
    CFG_COUNT_WEIGHT = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_DELAY,
    ST_SCAN,
    ST_MUL,
    ST_CMP,
    ST_DISP,
    ST_DONE
  } fsm_state_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] task_index;
    logic [TIME_W-1:0] time_amount;
  } in_item_t;

  typedef struct packed {
    logic              dispatched;
    logic [SLOT_W-1:0] dispatched_task;
    logic              choice_valid;
    logic [SLOT_W-1:0] choice_task;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic tick_step;
    logic delay_step;
    logic scan_step;
    logic mul_step;
    logic cmp_step;
    logic disp_step;
  } dp_cmd_t;

  typedef struct packed {
    logic last_slot;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> hdl/tss_ctrl.sv
`default_nettype none

module tss_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [tss_pkg::OP_W-1:0] op,
  output logic                   busy,
  output logic                   out_valid,
  output tss_pkg::dp_cmd_t       cmd,
  input  tss_pkg::dp_stat_t      stat
);
  import tss_pkg::*;

  fsm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (op)
            OP_TICK:  state_nxt = ST_TICK;
            OP_DELAY: state_nxt = ST_DELAY;
            OP_SCHED: state_nxt = ST_SCAN;
            default:  state_nxt = ST_DONE;
          endcase
        end
      end
      ST_TICK: begin
        if (stat.last_slot) state_nxt = ST_DONE;
      end
      ST_DELAY: state_nxt = ST_DONE;
      ST_SCAN: begin
        if (stat.last_slot) state_nxt = ST_MUL;
      end
      ST_MUL:  state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_DISP;
      ST_DISP: state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy           = (state_r != ST_IDLE);
    out_valid      = (state_r == ST_DONE);
    cmd            = '0;
    cmd.load       = (state_r == ST_IDLE) && start;
    cmd.tick_step  = (state_r == ST_TICK);
    cmd.delay_step = (state_r == ST_DELAY);
    cmd.scan_step  = (state_r == ST_SCAN);
    cmd.mul_step   = (state_r == ST_MUL);
    cmd.cmp_step   = (state_r == ST_CMP);
    cmd.disp_step  = (state_r == ST_DISP);
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("block stayed busy after the result strobe");

  a_scan_before_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> ($past(state_r) == ST_SCAN))
    else $error("weighting started without a finished slot scan");
`endif

endmodule

`default_nettype wire

>>> hdl/tss_datapath.sv
`default_nettype none

module tss_datapath #(
  parameter int MAX_TASKS = tss_pkg::MAX_TASKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tss_pkg::dp_cmd_t              cmd,
  output tss_pkg::dp_stat_t             stat,
  input  tss_pkg::in_item_t             in_data,
  input  logic                          cfg_we,
  input  logic [tss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tss_pkg::CFG_W-1:0]     cfg_data,
  output tss_pkg::out_item_t            out_data
);
  import tss_pkg::*;

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int N_W   = $clog2(MAX_TASKS + 1);
  localparam int SUM_W = N_W + CNT_W + 1;
  localparam int PP_W  = PRIO_W + WEIGHT_W;
  localparam int SP_W  = SUM_W + WEIGHT_W;
  localparam int CMP_W = SP_W + 1;

  // Configuration registers
  logic [TCOUNT_W-1:0] task_count_r;
  logic [CFG_W-1:0]    prio_r;
  logic [WEIGHT_W-1:0] pw_r;
  logic [WEIGHT_W-1:0] cw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_count_r <= TCOUNT_W'(1);
      prio_r       <= '0;
      pw_r         <= WEIGHT_W'(1);
      cw_r         <= WEIGHT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TASK_COUNT:   task_count_r <= cfg_data[TCOUNT_W-1:0];
        CFG_PRIORITIES:   prio_r       <= cfg_data;
        CFG_PRIO_WEIGHT:  pw_r         <= cfg_data[WEIGHT_W-1:0];
        CFG_COUNT_WEIGHT: cw_r         <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Active task count, clamped to 1..MAX_TASKS
  logic [N_W-1:0] n_eff;
  always_comb begin
    if (task_count_r == '0) begin
      n_eff = N_W'(1);
    end else if (32'(task_count_r) > MAX_TASKS) begin
      n_eff = N_W'(MAX_TASKS);
    end else begin
      n_eff = N_W'(task_count_r);
    end
  end

  // Latched transaction
  logic [SLOT_W-1:0] idx_r;
  logic [TIME_W-1:0] amt_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r <= in_data.task_index;
      amt_r <= in_data.time_amount;
    end
  end

  // Slot storage
  logic signed [SLEEP_W-1:0] sleep_r [MAX_TASKS];
  task_st_t                  st_r    [MAX_TASKS];
  logic [CNT_W-1:0]          cnt_r   [MAX_TASKS];
  logic [IDX_W-1:0]          walk_r;
  logic [IDX_W-1:0]          rr_r;

  logic [IDX_W:0]   rr_inc;
  logic [IDX_W-1:0] ptr;
  logic             idx_ok;
  logic [IDX_W-1:0] addr;
  logic [5:0]       addr_w;

  assign rr_inc = {1'b0, rr_r} + (IDX_W+1)'(1);
  assign ptr    = (rr_inc >= (IDX_W+1)'(n_eff)) ? '0 : rr_inc[IDX_W-1:0];
  assign idx_ok = (32'(idx_r) < 32'(n_eff));

  always_comb begin
    if (cmd.disp_step) begin
      addr = ptr;
    end else if (cmd.delay_step) begin
      addr = IDX_W'(idx_r);
    end else begin
      addr = walk_r;
    end
  end

  logic signed [SLEEP_W-1:0] sl;
  task_st_t                  st;
  logic [CNT_W-1:0]          cnt;
  logic [PRIO_W-1:0]         pri;

  assign sl     = sleep_r[addr];
  assign st     = st_r[addr];
  assign cnt    = cnt_r[addr];
  assign addr_w = 6'(addr);
  assign pri    = (addr_w < 6'd8) ? prio_r[addr_w[2:0]*PRIO_W +: PRIO_W] : '0;

  assign stat.last_slot = (N_W'(walk_r) == (n_eff - N_W'(1)));

  logic signed [SLEEP_W-1:0] sl_nxt;
  task_st_t                  st_nxt;
  logic [CNT_W-1:0]          cnt_nxt;
  logic                      slot_we;
  logic signed [SLEEP_W-1:0] amt_s;

  assign amt_s = $signed({1'b0, amt_r});

  always_comb begin
    sl_nxt  = sl;
    st_nxt  = st;
    cnt_nxt = cnt;
    slot_we = 1'b0;
    if (cmd.tick_step) begin
      slot_we = 1'b1;
      if (sl > 0) begin
        sl_nxt = sl - amt_s;
      end else begin
        sl_nxt = '0;
        st_nxt = TS_READY;
      end
    end else if (cmd.delay_step) begin
      slot_we = idx_ok;
      if (st != TS_WAIT) begin
        sl_nxt = amt_s;
        if (amt_r != '0) st_nxt = TS_WAIT;
      end
      if ((st_nxt == TS_WAIT) && (sl_nxt <= 0)) begin
        sl_nxt = '0;
        st_nxt = TS_READY;
      end
    end else if (cmd.disp_step) begin
      slot_we = 1'b1;
      if (st != TS_WAIT) begin
        st_nxt = TS_RUN;
        if (cnt != {CNT_W{1'b1}}) cnt_nxt = cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        sleep_r[i] <= '0;
        st_r[i]    <= TS_READY;
        cnt_r[i]   <= CNT_W'(1);
      end
      rr_r <= '0;
    end else begin
      if (slot_we) begin
        sleep_r[addr] <= sl_nxt;
        st_r[addr]    <= st_nxt;
        cnt_r[addr]   <= cnt_nxt;
      end
      if (cmd.disp_step) rr_r <= ptr;
    end
  end

  // Slot scan for the weighted choice
  logic [SUM_W-1:0]  sum_r;
  logic              has_p_r, has_c_r;
  logic [IDX_W-1:0]  p_idx_r, c_idx_r;
  logic [PRIO_W-1:0] p_pri_r, c_pri_r;
  logic [CNT_W-1:0]  p_cnt_r, c_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_r  <= '0;
      has_p_r <= 1'b0;
      has_c_r <= 1'b0;
    end else if (cmd.load) begin
      walk_r  <= '0;
      has_p_r <= 1'b0;
      has_c_r <= 1'b0;
    end else begin
      if (cmd.tick_step || cmd.scan_step) walk_r <= walk_r + IDX_W'(1);
      if (cmd.scan_step && (st == TS_READY)) begin
        if (pri > p_pri_r) has_p_r <= 1'b1;
        if (cnt < c_cnt_r) has_c_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sum_r   <= '0;
      p_pri_r <= '0;
      c_cnt_r <= CNT_W'(COUNT_LIMIT);
    end else if (cmd.scan_step) begin
      sum_r <= sum_r + SUM_W'(cnt) + SUM_W'(1);
      if (st == TS_READY) begin
        if (pri > p_pri_r) begin
          p_pri_r <= pri;
          p_idx_r <= walk_r;
          p_cnt_r <= cnt;
        end
        if (cnt < c_cnt_r) begin
          c_cnt_r <= cnt;
          c_idx_r <= walk_r;
          c_pri_r <= pri;
        end
      end
    end
  end

  // Weighted terms: one multiply per term, registered before the compare
  logic [SUM_W-1:0] slack_c, slack_p;
  logic [PP_W-1:0]  pc_r, pp_r;
  logic [SP_W-1:0]  sc_r, sp_r;

  assign slack_c = sum_r - SUM_W'(c_cnt_r) - SUM_W'(1);
  assign slack_p = sum_r - SUM_W'(p_cnt_r);

  always_ff @(posedge clk) begin
    if (cmd.mul_step) begin
      pc_r <= PP_W'(c_pri_r) * PP_W'(pw_r);
      pp_r <= PP_W'(p_pri_r) * PP_W'(pw_r);
      sc_r <= SP_W'(slack_c) * SP_W'(cw_r);
      sp_r <= SP_W'(slack_p) * SP_W'(cw_r);
    end
  end

  logic [CMP_W-1:0] lhs, rhs;
  assign lhs = CMP_W'(pc_r) + CMP_W'(sc_r);
  assign rhs = CMP_W'(pp_r) + CMP_W'(sp_r);

  out_item_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load) begin
      res_r <= '0;
    end else begin
      if (cmd.cmp_step) begin
        if (n_eff == N_W'(1)) begin
          res_r.choice_valid <= 1'b1;
          res_r.choice_task  <= '0;
        end else if (!has_p_r && !has_c_r) begin
          res_r.choice_valid <= 1'b0;
          res_r.choice_task  <= '0;
        end else begin
          res_r.choice_valid <= 1'b1;
          if (!has_p_r || (has_c_r && (lhs >= rhs))) begin
            res_r.choice_task <= SLOT_W'(c_idx_r);
          end else begin
            res_r.choice_task <= SLOT_W'(p_idx_r);
          end
        end
      end
      if (cmd.disp_step) begin
        res_r.dispatched      <= (st != TS_WAIT);
        res_r.dispatched_task <= SLOT_W'(ptr);
      end
    end
  end

  assign out_data = res_r;

`ifndef SYNTHESIS
  a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.disp_step |=> ((IDX_W+1)'(rr_r) < (IDX_W+1)'($past(n_eff))))
    else $error("round-robin pointer left the active slots");

  a_choice_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !res_r.choice_valid |-> (res_r.choice_task == '0))
    else $error("invalid choice carries a slot number");

  a_scan_no_update: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> !slot_we)
    else $error("slot storage written during the scan");
`endif

endmodule

`default_nettype wire

>>> hdl/task_scheduler_sleep_timers.sv
`default_nettype none

// Round-robin task scheduler with a sleep timer, a status and a dispatch count
// per task slot. Raise start with a transaction on in_data while busy is low;
// the single result appears on out_data for exactly one cycle with out_valid
// high, and must be taken then, as the block cannot be held off. Every
// transaction gives one result; tick, delay and no-op give all-zero fields.
// Slots are handled one per cycle by a walk over the slot registers, so with
// n active tasks (task_count clamped to 1..MAX_TASKS) a tick or a schedule
// walks all n slots, a schedule then weights, compares and dispatches, and a
// delay touches only its own slot; no new transaction is taken while busy.
// The result strobe falls in the last busy cycle. Configuration writes on the
// cfg_ port take effect at once and must only be issued while busy is low.
module task_scheduler_sleep_timers #(
  parameter int MAX_TASKS = tss_pkg::MAX_TASKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  tss_pkg::in_item_t             in_data,
  output logic                          out_valid,
  output tss_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [tss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tss_pkg::CFG_W-1:0]     cfg_data
);
  import tss_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequence each transaction: decode the op, step the slot walk, hand the
  // weighted terms through multiply and compare, dispatch, then raise the strobe.
  tss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .op        (in_data.op),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Hold slot state, configuration and the result register.
  tss_datapath #(
    .MAX_TASKS (MAX_TASKS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
